### hw/rtl/crc16_byte_stream_defines.svh
// ---------------------------------------------------------------------------
// crc16 byte stream assertion macros
// shared helpers for the checker, expects clk and arst_n in scope
// ---------------------------------------------------------------------------
`ifndef CRC16_BYTE_STREAM_DEFINES_SVH
`define CRC16_BYTE_STREAM_DEFINES_SVH

// same-cycle implication
`define CRC16BS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("crc16 byte stream check failed");

// next-cycle implication
`define CRC16BS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("crc16 byte stream check failed");

`endif

### hw/rtl/crc16bs_pkg.sv
// ---------------------------------------------------------------------------
// crc16bs_pkg
// types, constants and the crc step function of the crc16 byte stream
// ---------------------------------------------------------------------------
package crc16bs_pkg;

	localparam int unsigned CRC_W = 24;
	localparam int unsigned OUT_W = 16;

	// 0x01100000 ^ 0x2100 with the bit that falls out the top dropped
	localparam logic [CRC_W-1:0] CRC_POLY       = 24'h102100;
	localparam logic [OUT_W-1:0] CRC_NULL_VALUE = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_DATA   = 2'd0,
		OP_FINISH = 2'd1,
		OP_NULL   = 2'd2
	} op_t;

	// eight shift and conditional xor steps
	function automatic logic [CRC_W-1:0] crc_steps8(input logic [CRC_W-1:0] r);
		logic [CRC_W-1:0] v;
		v = r;
		for (int k = 0; k < 8; k++) begin
			v = {v[CRC_W-2:0], 1'b0} ^ (v[CRC_W-1] ? CRC_POLY : '0);
		end
		return v;
	endfunction

endpackage

### hw/rtl/crc16_byte_stream.sv
// ---------------------------------------------------------------------------
// crc16_byte_stream
// augmented crc16 (poly 0x1021) over a byte stream, sign-extended byte merge
// ---------------------------------------------------------------------------
// channel  | handshake              | payload
// byte in  | byte_valid, byte_stall | operation, data_byte, last
// crc out  | crc_valid, crc_stall   | crc_value
//
// one transaction per cycle sustained while crc_stall is low; a result passes
// the input register, two finishing stages and the output register
// the crc register update is a single eight-step xor stage on the input
// register; the sixteen augmenting steps are split over two stages
// arst_n clears all valid flags and the crc register
// every stage holds its own valid, so bytes keep flowing while a result waits
module crc16_byte_stream
	import crc16bs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	output logic             byte_stall,
	input  logic [1:0]       operation,
	input  logic [7:0]       data_byte,
	input  logic             last,
	output logic             crc_valid,
	input  logic             crc_stall,
	output logic [OUT_W-1:0] crc_value
);

	logic             valid_s1, valid_s2, valid_s3, crc_valid_q;
	logic [1:0]       operation_s1;
	logic [7:0]       data_byte_s1;
	logic             last_s1;
	logic [CRC_W-1:0] crc_q;
	logic [CRC_W-1:0] fin_s2, fin_s3;
	logic             null_s2, null_s3;
	logic [OUT_W-1:0] crc_value_q;

	logic             out_free, s3_free, s2_free, s1_free;
	logic [CRC_W-1:0] ext, mixed, crc_nxt, fin_nxt, fin_s3_nxt, fin_out;
	logic             res_nxt, null_nxt;

	assign out_free = !crc_valid_q || !crc_stall;
	assign s3_free  = !valid_s3 || out_free;
	assign s2_free  = !valid_s2 || s3_free;
	assign s1_free  = !valid_s1 || s2_free;

	assign byte_stall = !s1_free;
	assign crc_valid  = crc_valid_q;
	assign crc_value  = crc_value_q;

	// merge byte and run the register update
	assign ext   = {{(CRC_W-8){data_byte_s1[7]}}, data_byte_s1};
	assign mixed = crc_steps8(crc_q | ext);

	always_comb begin
		crc_nxt  = crc_q;
		fin_nxt  = mixed;
		res_nxt  = 1'b0;
		null_nxt = 1'b0;
		case (operation_s1)
			OP_DATA: begin
				crc_nxt = last_s1 ? '0 : mixed;
				res_nxt = last_s1;
			end
			OP_FINISH: begin
				crc_nxt = '0;
				fin_nxt = crc_q;
				res_nxt = 1'b1;
			end
			OP_NULL: begin
				crc_nxt  = '0;
				res_nxt  = 1'b1;
				null_nxt = 1'b1;
			end
			default: begin
				crc_nxt = crc_q;
				res_nxt = 1'b0;
			end
		endcase
	end

	assign fin_s3_nxt = crc_steps8(fin_s2);
	assign fin_out    = crc_steps8(fin_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			crc_valid_q <= 1'b0;
			crc_q       <= '0;
		end else begin
			if (s1_free) begin
				valid_s1 <= byte_valid;
			end
			if (valid_s1 && s1_free) begin
				crc_q <= crc_nxt;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1 && res_nxt;
			end
			if (s3_free) begin
				valid_s3 <= valid_s2;
			end
			if (out_free) begin
				crc_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && byte_valid) begin
			operation_s1 <= operation;
			data_byte_s1 <= data_byte;
			last_s1      <= last;
		end
		if (s2_free && valid_s1) begin
			fin_s2  <= fin_nxt;
			null_s2 <= null_nxt;
		end
		if (s3_free && valid_s2) begin
			fin_s3  <= fin_s3_nxt;
			null_s3 <= null_s2;
		end
		if (out_free && valid_s3) begin
			crc_value_q <= null_s3 ? CRC_NULL_VALUE : fin_out[CRC_W-1:CRC_W-OUT_W];
		end
	end

endmodule

### hw/rtl/crc16bs_checker.sv
// ---------------------------------------------------------------------------
// crc16bs_checker
// port-level checks of the crc16 byte stream, bound to the top level
// ---------------------------------------------------------------------------
`include "crc16_byte_stream_defines.svh"

module crc16bs_checker
	import crc16bs_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             byte_stall,
	input logic             crc_valid,
	input logic             crc_stall,
	input logic [OUT_W-1:0] crc_value
);

	// a stalled result transaction holds
	`CRC16BS_ASSERT_NXT(a_out_hold, crc_valid && crc_stall, crc_valid)
	`CRC16BS_ASSERT_NXT(a_out_stable, crc_valid && crc_stall, $stable(crc_value))

	// back pressure on bytes only comes from a held result
	`CRC16BS_ASSERT_IMP(a_idle_no_stall, !crc_valid, !byte_stall)
	`CRC16BS_ASSERT_IMP(a_stall_source, byte_stall, crc_valid && crc_stall)

endmodule

bind crc16_byte_stream crc16bs_checker u_crc16bs_checker (.*);

### test/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for crc16_byte_stream: a queue-fed driver sends byte,
// finish, null and unused-code transactions; a bit-level crc model predicts
// each finished crc and the monitor compares results in order; random idling
// on the sender and random stall on the receiver in two of three phases
// ---------------------------------------------------------------------------
module tb;
	import crc16bs_pkg::*;

	localparam logic [1:0]  OP_UNUSED   = 2'd3;
	localparam logic [24:0] FOLD_POLY   = 25'h1102100;
	localparam int          WATCHDOG    = 4000;
	localparam int          DRAIN_WAIT  = 8;
	localparam int          PHASE_ITEMS = 150;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
		logic       fin;
	} byte_txn_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             byte_valid = 1'b0;
	logic             byte_stall;
	logic [1:0]       operation = OP_FINISH;
	logic [7:0]       data_byte = '0;
	logic             last = 1'b0;
	logic             crc_valid;
	logic             crc_stall = 1'b0;
	logic [OUT_W-1:0] crc_value;

	byte_txn_t        pending_txns[$];
	logic [OUT_W-1:0] crc_expected[$];
	byte_txn_t        cur_txn = '0;
	logic [23:0]      crc_state = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_send = 1'b0;
	int mismatches = 0;
	int idle_cycles = 0;
	int n_bytes = 0;
	int n_msgs = 0;
	int n_nulls = 0;
	int n_ignored = 0;
	int n_checked = 0;
	int n_items = 0;

	crc16_byte_stream dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.operation  (operation),
		.data_byte  (data_byte),
		.last       (last),
		.crc_valid  (crc_valid),
		.crc_stall  (crc_stall),
		.crc_value  (crc_value)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [23:0] crc_shift(input logic [23:0] r, input int n);
		logic [24:0] w;
		for (int k = 0; k < n; k++) begin
			w = {r, 1'b0};
			if (w[24])
				w = w ^ FOLD_POLY;
			r = w[23:0];
		end
		return r;
	endfunction

	task automatic finish_message();
		logic [23:0] r;
		r = crc_shift(crc_state, 16);
		crc_expected.push_back(r[23:8]);
		crc_state = '0;
		n_msgs++;
	endtask

	task automatic predict_crc(input byte_txn_t t);
		logic [23:0] ext;
		case (t.op)
			OP_DATA: begin
				ext = t.data[7] ? {16'hFFFF, t.data} : {16'h0000, t.data};
				crc_state = crc_shift(crc_state | ext, 8);
				n_bytes++;
				if (t.fin)
					finish_message();
			end
			OP_FINISH: begin
				finish_message();
			end
			OP_NULL: begin
				crc_state = '0;
				crc_expected.push_back(CRC_NULL_VALUE);
				n_nulls++;
			end
			default: begin
				n_ignored++;
			end
		endcase
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
		end else begin
			if (byte_valid && !byte_stall)
				predict_crc(cur_txn);
			if (!byte_valid || !byte_stall) begin
				if (!hold_send && pending_txns.size() > 0 &&
				    $urandom_range(99) >= send_idle_pct) begin
					cur_txn = pending_txns.pop_front();
					byte_valid <= 1'b1;
					operation  <= cur_txn.op;
					data_byte  <= cur_txn.data;
					last       <= cur_txn.fin;
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		logic [OUT_W-1:0] want;
		if (!arst_n) begin
			crc_stall <= 1'b0;
		end else begin
			if (crc_valid && !crc_stall) begin
				if (crc_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result crc_value=%h", crc_value);
				end else begin
					want = crc_expected.pop_front();
					n_checked++;
					if (crc_value !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("crc_value mismatch: expected %h actual %h",
								want, crc_value);
					end
				end
			end
			crc_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && !byte_stall) || (crc_valid && !crc_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("timeout after %0d cycles without a transaction", idle_cycles);
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic push_txn(input logic [1:0] op, input logic [7:0] data, input logic fin);
		byte_txn_t t;
		t.op = op;
		t.data = data;
		t.fin = fin;
		pending_txns.push_back(t);
		if (op != OP_UNUSED)
			n_items++;
	endtask

	task automatic push_random_message();
		int r;
		int len;
		bit end_on_last;
		r = $urandom_range(99);
		if (r < 5) begin
			push_txn(OP_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)));
		end else if (r < 10) begin
			push_txn(OP_NULL, 8'($urandom_range(255)), 1'($urandom_range(1)));
		end else begin
			len = ($urandom_range(19) == 0) ? $urandom_range(40, 16) : $urandom_range(10);
			end_on_last = $urandom_range(2) != 0;
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(29) == 0)
					push_txn(OP_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)));
				// broken message: dropped by a null buffer
				if ($urandom_range(39) == 0) begin
					push_txn(OP_NULL, 8'($urandom_range(255)), 1'($urandom_range(1)));
					return;
				end
				push_txn(OP_DATA, 8'($urandom_range(255)), end_on_last && (i == len - 1));
			end
			if (len == 0 || !end_on_last)
				push_txn(OP_FINISH, 8'($urandom_range(255)), 1'($urandom_range(1)));
		end
	endtask

	task automatic wait_drained();
		while (pending_txns.size() != 0 || byte_valid)
			@(posedge clk);
		while (crc_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic fill_random(input int count);
		int target;
		target = n_items + count;
		while (n_items < target)
			push_random_message();
	endtask

	initial begin
		logic [7:0] check_str[9];
		check_str = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
		send_idle_pct = 6;
		recv_stall_pct = 78;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty message, null buffer, single-byte extremes
		push_txn(OP_FINISH, 8'hFF, 1'b1);
		push_txn(OP_NULL, 8'h00, 1'b0);
		push_txn(OP_DATA, 8'h00, 1'b1);
		push_txn(OP_DATA, 8'hFF, 1'b1);
		push_txn(OP_DATA, 8'h7F, 1'b1);
		push_txn(OP_DATA, 8'h80, 1'b1);
		// standard check string
		foreach (check_str[i])
			push_txn(OP_DATA, check_str[i], i == 8);
		// null buffer mid-message
		push_txn(OP_DATA, 8'hA5, 1'b0);
		push_txn(OP_DATA, 8'h3C, 1'b0);
		push_txn(OP_NULL, 8'hFF, 1'b1);
		// unused code mid-message leaves the state alone
		push_txn(OP_DATA, 8'h12, 1'b0);
		push_txn(OP_UNUSED, 8'hFF, 1'b1);
		push_txn(OP_DATA, 8'h34, 1'b1);
		// finish after bytes
		push_txn(OP_DATA, 8'h80, 1'b0);
		push_txn(OP_DATA, 8'h01, 1'b0);
		push_txn(OP_FINISH, 8'h55, 1'b0);

		fill_random(PHASE_ITEMS);
		wait_drained();

		send_idle_pct = 78;
		recv_stall_pct = 6;
		fill_random(PHASE_ITEMS / 2);
		wait_drained();
		// with every result back, the sender holds off while the queue is filled
		hold_send = 1'b1;
		fill_random(PHASE_ITEMS / 2);
		repeat (DRAIN_WAIT) @(posedge clk);
		hold_send = 1'b0;
		wait_drained();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		fill_random(PHASE_ITEMS);
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d data bytes, %0d finished messages, %0d null buffers,",
			n_bytes, n_msgs, n_nulls);
		$display("%0d unused codes; checked %0d crc results, %0d mismatches",
			n_ignored, n_checked, mismatches);
		if (mismatches == 0 && crc_expected.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

### crc16_byte_stream.f
+incdir+hw/rtl
hw/rtl/crc16bs_pkg.sv
hw/rtl/crc16_byte_stream.sv
hw/rtl/crc16bs_checker.sv
test/tb.sv
